[sv/josephus_elimination_with_codes_macros.svh]
// ----------------------------------------------------------------------------
// Josephus elimination assertion macros
// Shared property wrappers for the port-level checker. All properties are
// clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOSEPHUS_ELIMINATION_WITH_CODES_MACROS_SVH
`define JOSEPHUS_ELIMINATION_WITH_CODES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JEC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/jec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus elimination package
// Default sizes, fixed port widths and the controller state type.
// ----------------------------------------------------------------------------
package jec_pkg;

	localparam int MAX_PEOPLE_DEF = 64;
	localparam int CODE_BITS_DEF  = 8;

	// Widths fixed by the port definition.
	localparam int IN_CODE_BITS = 8;
	localparam int INIT_BITS    = 8;
	localparam int PNUM_BITS    = 7;

	localparam logic [INIT_BITS-1:0] INIT_COUNT_RESET = 8'd1;

	typedef logic [PNUM_BITS-1:0] pnum_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CHECK,
		ST_WALK,
		ST_HIT
	} state_t;

endpackage

[sv/jec_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus elimination table memory
// Single write port, single registered read port. The read data holds its
// value in cycles with no read.
// ----------------------------------------------------------------------------
module jec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/jec_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus elimination controller
// Loads codes and links, then walks the link table, one ST_CHECK/ST_WALK pass per step,
// unlinks each person reached and presents it in the output register.
// ----------------------------------------------------------------------------
module jec_ctrl #(
	parameter int MAX_PEOPLE = jec_pkg::MAX_PEOPLE_DEF,
	parameter int CODE_BITS  = jec_pkg::CODE_BITS_DEF,
	parameter int IDX_BITS   = $clog2(MAX_PEOPLE)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [jec_pkg::INIT_BITS-1:0]    cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [jec_pkg::IN_CODE_BITS-1:0] person_code,
	input  logic                             last_person,
	output logic                             out_valid,
	input  logic                             out_stall,
	output jec_pkg::pnum_t                   person_number,
	output logic                             final_out,
	// link table
	output logic                             link_we,
	output logic [IDX_BITS-1:0]              link_waddr,
	output logic [IDX_BITS-1:0]              link_wdata,
	output logic                             link_re,
	output logic [IDX_BITS-1:0]              link_raddr,
	input  logic [IDX_BITS-1:0]              link_rdata,
	// code table
	output logic                             code_we,
	output logic [IDX_BITS-1:0]              code_waddr,
	output logic [CODE_BITS-1:0]             code_wdata,
	output logic                             code_re,
	output logic [IDX_BITS-1:0]              code_raddr,
	input  logic [CODE_BITS-1:0]             code_rdata
);

	localparam int CNT_W    = $clog2(MAX_PEOPLE + 1);
	localparam int CNT_BITS = (CODE_BITS > jec_pkg::INIT_BITS) ? CODE_BITS : jec_pkg::INIT_BITS;

	jec_pkg::state_t state_q, state_d;

	logic [jec_pkg::INIT_BITS-1:0] init_q;
	logic [CNT_W-1:0]              loaded_q;
	logic [CNT_W-1:0]              alive_q;
	logic [IDX_BITS-1:0]           cur_q;
	logic [IDX_BITS-1:0]           prev_q;
	logic [CNT_BITS-1:0]           target_q;
	logic [CNT_BITS-1:0]           step_q;
	logic                          out_valid_q;
	jec_pkg::pnum_t                pnum_q;
	logic                          final_q;

	logic in_acc;
	logic full;
	logic load_en;
	logic out_free;
	logic more_steps;
	logic last_idx;

	assign in_acc     = in_valid && !in_stall;
	assign full       = (loaded_q == CNT_W'(MAX_PEOPLE));
	assign load_en    = in_acc && !full;
	assign out_free   = !out_valid_q || !out_stall;
	assign more_steps = (step_q < target_q);
	assign last_idx   = (loaded_q == CNT_W'(MAX_PEOPLE - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			jec_pkg::ST_LOAD: begin
				if (in_acc && last_person) begin
					state_d = jec_pkg::ST_CHECK;
				end
			end
			jec_pkg::ST_CHECK: begin
				state_d = more_steps ? jec_pkg::ST_WALK : jec_pkg::ST_HIT;
			end
			jec_pkg::ST_WALK: begin
				state_d = jec_pkg::ST_CHECK;
			end
			jec_pkg::ST_HIT: begin
				if (out_free) begin
					state_d = (alive_q == CNT_W'(1)) ? jec_pkg::ST_LOAD : jec_pkg::ST_CHECK;
				end
			end
			default: begin
				state_d = jec_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		link_we    = 1'b0;
		link_waddr = loaded_q[IDX_BITS-1:0];
		link_wdata = '0;
		link_re    = 1'b0;
		link_raddr = cur_q;
		code_we    = 1'b0;
		code_waddr = loaded_q[IDX_BITS-1:0];
		code_wdata = CODE_BITS'(person_code);
		code_re    = 1'b0;
		code_raddr = cur_q;
		case (state_q)
			jec_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				// Each loaded person links forward; the final one closes the circle.
				link_we    = load_en;
				code_we    = load_en;
				link_wdata = (last_idx || last_person) ? '0
					: loaded_q[IDX_BITS-1:0] + IDX_BITS'(1);
			end
			jec_pkg::ST_CHECK: begin
				link_re = 1'b1;
				code_re = !more_steps;
			end
			jec_pkg::ST_WALK: begin
			end
			jec_pkg::ST_HIT: begin
				// Unlink the person reached: its predecessor skips over it.
				link_we    = out_free;
				link_waddr = prev_q;
				link_wdata = link_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= jec_pkg::ST_LOAD;
			init_q   <= jec_pkg::INIT_COUNT_RESET;
			loaded_q <= '0;
			alive_q  <= '0;
			cur_q    <= '0;
			prev_q   <= '0;
			target_q <= '0;
			step_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
			case (state_q)
				jec_pkg::ST_LOAD: begin
					if (load_en) begin
						loaded_q <= loaded_q + CNT_W'(1);
					end
					if (in_acc && last_person) begin
						cur_q    <= '0;
						prev_q   <= full ? IDX_BITS'(MAX_PEOPLE - 1) : loaded_q[IDX_BITS-1:0];
						alive_q  <= full ? loaded_q : loaded_q + CNT_W'(1);
						target_q <= (init_q == '0) ? CNT_BITS'(1) : CNT_BITS'(init_q);
						step_q   <= CNT_BITS'(1);
						loaded_q <= '0;
					end
				end
				jec_pkg::ST_WALK: begin
					prev_q <= cur_q;
					cur_q  <= link_rdata;
					step_q <= step_q + CNT_BITS'(1);
				end
				jec_pkg::ST_HIT: begin
					if (out_free) begin
						cur_q    <= link_rdata;
						alive_q  <= alive_q - CNT_W'(1);
						target_q <= (code_rdata == '0) ? CNT_BITS'(1) : CNT_BITS'(code_rdata);
						step_q   <= CNT_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == jec_pkg::ST_HIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == jec_pkg::ST_HIT && out_free) begin
			pnum_q  <= jec_pkg::pnum_t'(cur_q) + jec_pkg::pnum_t'(1);
			final_q <= (alive_q == CNT_W'(1));
		end
	end

	assign out_valid     = out_valid_q;
	assign person_number = pnum_q;
	assign final_out     = final_q;

endmodule

[sv/josephus_elimination_with_codes.sv]
`timescale 1ns / 1ps
// Loading transactions are taken while in_stall is low. After the transaction marked last,
// each elimination steps over count people around the circle, where count is the count in force
// (initial_count for the first, then the code of the person just eliminated).
// Each step reads the link memory once; loading stays closed until the final result.
// Reset clears the controller and sets initial_count to 1; the tables need no clearing.
// ----------------------------------------------------------------------------
// Josephus elimination with codes
// Top level: controller plus the link and code table memories.
// ----------------------------------------------------------------------------
module josephus_elimination_with_codes #(
	parameter int MAX_PEOPLE = jec_pkg::MAX_PEOPLE_DEF,
	parameter int CODE_BITS  = jec_pkg::CODE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [jec_pkg::INIT_BITS-1:0]    cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [jec_pkg::IN_CODE_BITS-1:0] person_code,
	input  logic                             last_person,
	output logic                             out_valid,
	input  logic                             out_stall,
	output jec_pkg::pnum_t                   person_number,
	output logic                             final_out
);

	localparam int IDX_BITS = $clog2(MAX_PEOPLE);

	logic                 link_we;
	logic [IDX_BITS-1:0]  link_waddr;
	logic [IDX_BITS-1:0]  link_wdata;
	logic                 link_re;
	logic [IDX_BITS-1:0]  link_raddr;
	logic [IDX_BITS-1:0]  link_rdata;
	logic                 code_we;
	logic [IDX_BITS-1:0]  code_waddr;
	logic [CODE_BITS-1:0] code_wdata;
	logic                 code_re;
	logic [IDX_BITS-1:0]  code_raddr;
	logic [CODE_BITS-1:0] code_rdata;

	jec_ctrl #(
		.MAX_PEOPLE (MAX_PEOPLE),
		.CODE_BITS  (CODE_BITS),
		.IDX_BITS   (IDX_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.person_code   (person_code),
		.last_person   (last_person),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.person_number (person_number),
		.final_out     (final_out),
		.link_we       (link_we),
		.link_waddr    (link_waddr),
		.link_wdata    (link_wdata),
		.link_re       (link_re),
		.link_raddr    (link_raddr),
		.link_rdata    (link_rdata),
		.code_we       (code_we),
		.code_waddr    (code_waddr),
		.code_wdata    (code_wdata),
		.code_re       (code_re),
		.code_raddr    (code_raddr),
		.code_rdata    (code_rdata)
	);

	jec_ram #(
		.WIDTH (IDX_BITS),
		.DEPTH (MAX_PEOPLE)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	jec_ram #(
		.WIDTH (CODE_BITS),
		.DEPTH (MAX_PEOPLE)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_wdata),
		.re    (code_re),
		.raddr (code_raddr),
		.rdata (code_rdata)
	);

endmodule

[sv/jec_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus elimination port checker
// Watches the top-level ports and flags ordering and range violations.
// ----------------------------------------------------------------------------
`include "josephus_elimination_with_codes_macros.svh"

module jec_checker #(
	parameter int MAX_PEOPLE = jec_pkg::MAX_PEOPLE_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           last_person,
	input logic           out_valid,
	input logic           out_stall,
	input jec_pkg::pnum_t person_number,
	input logic           final_out
);

	// A stalled result transaction holds its payload.
	`JEC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(person_number) && $stable(final_out), "stalled result changed")

	// Person numbers stay within the circle size.
	`JEC_ASSERT_SAME(a_pnum_range, out_valid, person_number != '0 && person_number <= jec_pkg::pnum_t'(MAX_PEOPLE), "person number out of range")

	// A last-marked transaction starts elimination, so loading pauses.
	`JEC_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last_person, in_stall, "input taken during elimination start")

	// While a result other than the final one is held, loading stays closed.
	`JEC_ASSERT_SAME(a_busy_mid_round, out_valid && !final_out, in_stall, "input open before the final result")

endmodule

bind josephus_elimination_with_codes jec_checker #(.MAX_PEOPLE(MAX_PEOPLE)) u_checker (.*);
